@@ src/qrs_pkg.sv @@
// Shared types and codes for the quadratic root solver.
// No dependencies.
`default_nettype none

package qrs_pkg;

  typedef logic [1:0] root_count_t;

  // Number of distinct real roots
  localparam root_count_t CNT_NONE = 2'd0;
  localparam root_count_t CNT_ONE  = 2'd1;
  localparam root_count_t CNT_TWO  = 2'd2;

endpackage

`default_nettype wire

@@ src/quadratic_root_solver_unit.sv @@
// Quadratic root solver: fully pipelined real roots of a*x^2 + b*x + c = 0.
// Depends on qrs_pkg.
//
// A request (coef_a_i, coef_b_i, coef_c_i) is taken at every rising edge with
// start_i high; busy_o is always low, so one coefficient set enters per cycle.
// Each result appears for one cycle with result_valid_o high, in request order,
// with roots in Q16.16 at the default parameters. Most register stages are in the
// bit-serial square root pipeline (DATA_WIDTH+1 stages, one root bit each) and the
// restoring divider pipeline (DATA_WIDTH+FRAC_BITS+2 stages, one quotient bit each,
// both roots in parallel). The discriminant is exact; roots truncate toward zero
// and clamp to the output range with saturated_o set. A zero coef_a_i gives
// degenerate_o.
`default_nettype none

module quadratic_root_solver_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  output logic                         busy_o,
  input  wire  signed [DATA_WIDTH-1:0] coef_a_i,
  input  wire  signed [DATA_WIDTH-1:0] coef_b_i,
  input  wire  signed [DATA_WIDTH-1:0] coef_c_i,
  output logic                         result_valid_o,
  output qrs_pkg::root_count_t         root_count_o,
  output logic signed [DATA_WIDTH-1:0] root_plus_o,
  output logic signed [DATA_WIDTH-1:0] root_minus_o,
  output logic                         saturated_o,
  output logic                         degenerate_o
);
  import qrs_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;        // product width
  localparam int DW  = 2 * W + 2;    // discriminant width, even
  localparam int SW  = W + 1;        // square root width
  localparam int RW  = SW + 2;       // square root remainder width
  localparam int NW  = W + 3;        // signed numerator width
  localparam int MW  = W + 2;        // numerator magnitude width
  localparam int QW  = MW + F;       // dividend / quotient width
  localparam int RMW = W + 2;        // divider remainder width

  // Item attributes carried alongside the data
  typedef struct packed {
    logic                a_zero;
    logic                no_root;
    logic                rep;
    logic                a_neg;
    logic [W-1:0]        am;
    logic signed [W-1:0] b;
  } sb_t;

  assign busy_o = 1'b0;

  // ---------------- stage 0: magnitudes and signs ----------------
  logic         v0_q;
  sb_t          sb0_q;
  logic [W-1:0] bm0_q, cm0_q;
  logic         cneg0_q, czero0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sb0_q.a_zero  <= (coef_a_i == '0);
    sb0_q.no_root <= 1'b0;
    sb0_q.rep     <= 1'b0;
    sb0_q.a_neg   <= coef_a_i[W-1];
    sb0_q.am      <= coef_a_i[W-1] ? W'(-coef_a_i) : coef_a_i;
    sb0_q.b       <= coef_b_i;
    bm0_q         <= coef_b_i[W-1] ? W'(-coef_b_i) : coef_b_i;
    cm0_q         <= coef_c_i[W-1] ? W'(-coef_c_i) : coef_c_i;
    cneg0_q       <= coef_c_i[W-1];
    czero0_q      <= (coef_c_i == '0);
  end

  // ---------------- stage 1: products b*b and a*c ----------------
  logic          v1_q;
  sb_t           sb1_q;
  logic [PW-1:0] bb1_q, ac1_q;
  logic          cneg1_q, czero1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sb1_q    <= sb0_q;
    bb1_q    <= bm0_q * bm0_q;
    ac1_q    <= sb0_q.am * cm0_q;
    cneg1_q  <= cneg0_q;
    czero1_q <= czero0_q;
  end

  // ---------------- stage 2: discriminant ----------------
  logic [DW-1:0] bb_ext, ac4_ext, d_add, d_sub;
  logic          d_is_sum, ac_gt_bb;
  sb_t           sb2_d;

  always_comb begin
    bb_ext   = {2'b00, bb1_q};
    ac4_ext  = {ac1_q, 2'b00};
    d_add    = bb_ext + ac4_ext;
    d_sub    = bb_ext - ac4_ext;
    d_is_sum = (sb1_q.a_neg != cneg1_q) || czero1_q;
    ac_gt_bb = ac4_ext > bb_ext;
    sb2_d         = sb1_q;
    sb2_d.no_root = !d_is_sum && ac_gt_bb;
    sb2_d.rep     = d_is_sum ? (d_add == '0) : (d_sub == '0);
  end

  // Square root pipeline arrays; entry 0 is the discriminant stage output
  logic          sq_v_q    [0:SW];
  sb_t           sq_sb_q   [0:SW];
  logic [DW-1:0] sq_op_q   [0:SW];
  logic [RW-1:0] sq_rem_q  [0:SW];
  logic [SW-1:0] sq_root_q [0:SW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else begin
      sq_v_q[0] <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_sb_q[0]   <= sb2_d;
    sq_op_q[0]   <= d_is_sum ? d_add : d_sub;
    sq_rem_q[0]  <= '0;
    sq_root_q[0] <= '0;
  end

  // ---------------- square root: one root bit per stage ----------------
  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    logic [RW-1:0] rem_sh, trial;
    logic          take;

    always_comb begin
      rem_sh = {sq_rem_q[k][RW-3:0], sq_op_q[k][DW-1:DW-2]};
      trial  = {sq_root_q[k], 2'b01};
      take   = rem_sh >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      sq_sb_q[k+1]   <= sq_sb_q[k];
      sq_op_q[k+1]   <= {sq_op_q[k][DW-3:0], 2'b00};
      sq_rem_q[k+1]  <= take ? (rem_sh - trial) : rem_sh;
      sq_root_q[k+1] <= {sq_root_q[k][SW-2:0], take};
    end
  end

  // ---------------- numerators -b + s and -b - s ----------------
  logic signed [NW-1:0] nb, s_ext, n_plus, n_minus;

  always_comb begin
    nb      = -NW'(sq_sb_q[SW].b);
    s_ext   = {2'b00, sq_root_q[SW]};
    n_plus  = nb + s_ext;
    n_minus = nb - s_ext;
  end

  // Divider pipeline arrays, lane 0 for the plus root, lane 1 for the minus root
  logic           dv_v_q   [0:QW];
  sb_t            dv_sb_q  [0:QW];
  logic [1:0]     dv_neg_q [0:QW];
  logic [QW-1:0]  dv_num_q [0:QW][0:1];
  logic [RMW-1:0] dv_rem_q [0:QW][0:1];
  logic [QW-1:0]  dv_quo_q [0:QW][0:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else begin
      dv_v_q[0] <= sq_v_q[SW];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_sb_q[0]     <= sq_sb_q[SW];
    dv_neg_q[0][0] <= n_plus[NW-1] != sq_sb_q[SW].a_neg;
    dv_neg_q[0][1] <= n_minus[NW-1] != sq_sb_q[SW].a_neg;
    dv_num_q[0][0] <= {(n_plus[NW-1] ? MW'(-n_plus) : MW'(n_plus)), {F{1'b0}}};
    dv_num_q[0][1] <= {(n_minus[NW-1] ? MW'(-n_minus) : MW'(n_minus)), {F{1'b0}}};
    dv_rem_q[0][0] <= '0;
    dv_rem_q[0][1] <= '0;
    dv_quo_q[0][0] <= '0;
    dv_quo_q[0][1] <= '0;
  end

  // ---------------- divider: one quotient bit per stage ----------------
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [RMW-1:0] den;

    assign den = {1'b0, dv_sb_q[j].am, 1'b0};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j+1] <= 1'b0;
      end else begin
        dv_v_q[j+1] <= dv_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_sb_q[j+1]  <= dv_sb_q[j];
      dv_neg_q[j+1] <= dv_neg_q[j];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [RMW-1:0] r_sh;
      logic           ge;

      always_comb begin
        r_sh = {dv_rem_q[j][l][RMW-2:0], dv_num_q[j][l][QW-1]};
        ge   = r_sh >= den;
      end

      always_ff @(posedge clk_i) begin
        dv_num_q[j+1][l] <= {dv_num_q[j][l][QW-2:0], 1'b0};
        dv_rem_q[j+1][l] <= ge ? (r_sh - den) : r_sh;
        dv_quo_q[j+1][l] <= {dv_quo_q[j][l][QW-2:0], ge};
      end
    end
  end

  // ---------------- clamp, sign and result register ----------------
  logic [W-1:0] root_fin [0:1];
  logic [1:0]   sat_fin;

  for (genvar l = 0; l < 2; l++) begin : g_fin
    logic [W-1:0]  lim;
    logic [W-1:0]  qc;

    always_comb begin
      lim        = dv_neg_q[QW][l] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      sat_fin[l] = dv_quo_q[QW][l] > QW'(lim);
      qc         = sat_fin[l] ? lim : dv_quo_q[QW][l][W-1:0];
      root_fin[l] = dv_neg_q[QW][l] ? (-qc) : qc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= dv_v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_sb_q[QW].a_zero) begin
      root_count_o <= CNT_NONE;
      root_plus_o  <= '0;
      root_minus_o <= '0;
      saturated_o  <= 1'b0;
      degenerate_o <= 1'b1;
    end else if (dv_sb_q[QW].no_root) begin
      root_count_o <= CNT_NONE;
      root_plus_o  <= '0;
      root_minus_o <= '0;
      saturated_o  <= 1'b0;
      degenerate_o <= 1'b0;
    end else begin
      root_count_o <= dv_sb_q[QW].rep ? CNT_ONE : CNT_TWO;
      root_plus_o  <= root_fin[0];
      root_minus_o <= root_fin[1];
      saturated_o  <= |sat_fin;
      degenerate_o <= 1'b0;
    end
  end

  // ---------------- assertions ----------------
  a_degenerate_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && degenerate_o |->
      root_count_o == CNT_NONE && root_plus_o == '0 && !saturated_o)
    else $error("degenerate result carries roots");

  a_repeated_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && root_count_o == CNT_ONE |-> root_plus_o == root_minus_o)
    else $error("repeated root differs between lanes");

  a_sat_needs_roots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && saturated_o |-> root_count_o != CNT_NONE)
    else $error("saturation flagged without roots");

endmodule

`default_nettype wire
